/* sv/brmd_pkg.sv */
// shared types and constants for the block rotation minimum distance core
package brmd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIST_BITS   = 38;
  localparam int SHIFT_BITS  = 6;
  localparam int STEP_BITS   = 7;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int SQ_BITS     = 2 * DIFF_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ref_sample;
    logic signed [SAMPLE_BITS-1:0] cand_sample;
    logic                          last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [DIST_BITS-1:0]          min_sq_distance;
    logic [SHIFT_BITS-1:0]         best_shift;
    logic                          length_overflow;
    logic                          out_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_en;     // input channel open
    logic start_try;   // rewind element and rotated indexes for one shift
    logic issue;       // read one element pair into the distance pipeline
    logic cmp;         // compare finished sum, step to next shift or to emission
    logic emit_rd;     // read one candidate element for emission
    logic emit_wr;     // move it into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close;       // input item with last_element present
    logic last_issue;  // element index at final position
    logic pipe_busy;   // distance pipeline still holds elements
    logic out_free;    // output register can take an item
    logic more_tries;  // another shift follows the current one
  } dp_stat_t;

endpackage

/* sv/brmd_ctrl.sv */
// controller state machine: load, per-shift distance sweep, emission
module brmd_ctrl
  import brmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_RUN,
    S_DRAIN,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (stat.close) state_next = S_START;
      end
      S_START: begin
        cmd.start_try = 1'b1;
        state_next    = S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_next = S_CMP;
      end
      S_CMP: begin
        // next shift, or emission once the last shift is compared
        cmd.cmp    = 1'b1;
        state_next = stat.more_tries ? S_START : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (stat.out_free) begin
          cmd.emit_wr = 1'b1;
          state_next  = stat.last_issue ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/brmd_datapath.sv */
// datapath: sample memories, squared distance pipeline, best shift, output register
module brmd_datapath
  import brmd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  input  in_item_t             in_item,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int OW = $clog2(MAX_LEN + 2 * (1 << STEP_BITS) + 1);

  logic [SAMPLE_BITS-1:0] ref_mem  [MAX_LEN];
  logic [SAMPLE_BITS-1:0] cand_mem [MAX_LEN];

  logic [STEP_BITS-1:0] block_size;
  logic [STEP_BITS-1:0] step;
  logic [CW-1:0]        load_count;
  logic                 overflow_seen;
  logic [CW-1:0]        len;
  logic [CW-1:0]        len_m1;
  logic                 ovf;
  logic                 in_acc;
  logic                 has_room;

  logic [AW-1:0]        j;
  logic [AW-1:0]        k;
  logic [AW-1:0]        k_inc;
  logic [OW-1:0]        offset;
  logic [OW-1:0]        offset_next;
  logic                 more_tries;
  logic [AW-1:0]        s;
  logic [AW-1:0]        best_s;
  logic [AW-1:0]        best_off;
  logic [DIST_BITS-1:0] best_d;
  logic                 emitting;

  logic [SAMPLE_BITS-1:0] ref_q;
  logic [SAMPLE_BITS-1:0] cand_q;
  logic                   rd_en;
  logic                   v1;
  logic                   v2;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [SQ_BITS-1:0]   prod;
  logic [SQ_BITS-1:0]     sq;
  logic [DIST_BITS-1:0]   acc;
  logic [DIST_BITS:0]     acc_sum;

  assign step     = (block_size == '0) ? STEP_BITS'(1) : block_size;
  assign in_acc   = in_valid && cmd.load_en;
  assign has_room = (load_count < CW'(MAX_LEN));
  assign len_m1   = len - CW'(1);
  assign k_inc    = (k == len_m1[AW-1:0]) ? '0 : k + AW'(1);
  assign rd_en    = cmd.issue || cmd.emit_rd;

  // shift s+1 exists while (s+2)*step fits in the vector
  assign offset_next = offset + OW'(step);
  assign more_tries  = (offset_next + OW'(step)) <= OW'(len);

  assign diff    = $signed({ref_q[SAMPLE_BITS-1], ref_q}) -
                   $signed({cand_q[SAMPLE_BITS-1], cand_q});
  assign prod    = diff * diff;
  assign acc_sum = {1'b0, acc} + (DIST_BITS + 1)'(sq);

  assign stat.close      = in_valid && in_item.last_element;
  assign stat.last_issue = (j == len_m1[AW-1:0]);
  assign stat.pipe_busy  = v1 || v2;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.more_tries = more_tries;

  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      ref_mem[load_count[AW-1:0]] <= in_item.ref_sample;
    end
    if (rd_en) begin
      ref_q <= ref_mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      cand_mem[load_count[AW-1:0]] <= in_item.cand_sample;
    end
    if (rd_en) begin
      cand_q <= cand_mem[k];
    end
  end

  // load bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= STEP_BITS'(1);
      load_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_we) block_size <= cfg_data;
      if (in_acc) begin
        if (in_item.last_element) begin
          load_count    <= '0;
          overflow_seen <= 1'b0;
        end else if (has_room) begin
          load_count <= load_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // sweep control and best tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      emitting <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.emit_wr && stat.last_issue) emitting <= 1'b0;
      if (cmd.cmp && !more_tries) emitting <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_item.last_element) begin
      len    <= has_room ? load_count + CW'(1) : load_count;
      ovf    <= overflow_seen || !has_room;
      s      <= '0;
      offset <= '0;
    end
    if (cmd.start_try) begin
      j   <= '0;
      k   <= offset[AW-1:0];
      acc <= '0;
    end
    if (cmd.issue || cmd.emit_wr) begin
      j <= j + AW'(1);
      k <= k_inc;
    end
    if (v1) begin
      sq <= SQ_BITS'(prod);
    end
    if (v2) begin
      acc <= (acc_sum > (DIST_BITS + 1)'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_BITS-1:0];
    end
    if (cmd.cmp) begin
      if (s == '0 || acc < best_d) begin
        best_d   <= acc;
        best_s   <= s;
        best_off <= offset[AW-1:0];
      end
      if (more_tries) begin
        s      <= s + AW'(1);
        offset <= offset_next;
      end else begin
        j <= '0;
        k <= (s == '0 || acc < best_d) ? offset[AW-1:0] : best_off;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wr) begin
      out_item.out_sample      <= cand_q;
      out_item.min_sq_distance <= best_d;
      out_item.best_shift      <= SHIFT_BITS'(best_s);
      out_item.length_overflow <= ovf;
      out_item.out_last        <= stat.last_issue;
    end
  end

`ifndef SYNTHESIS
  a_pipe_order: assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("distance pipeline stage without predecessor");
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CW'(k) < len) && (CW'(j) < len))
    else $error("memory read beyond vector length");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CW'(MAX_LEN))
    else $error("load count beyond store depth");
  a_emit_after_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_rd |-> emitting)
    else $error("emission read before sweep finished");
`endif

endmodule

/* sv/block_rotation_min_distance_core.sv */
// top level of the block rotation minimum distance core
//
// usage:
// - block_size is written through cfg_we/cfg_data while the core is idle;
//   0 acts as 1, reset value is 1
// - input items (ref_sample, cand_sample, last_element) arrive on in_valid/in_ready,
//   one per cycle while loading; last_element closes the vector
// - pairs beyond MAX_LEN are dropped and flagged in length_overflow
// - after the closing item, each shift runs on the single
//   multiply-accumulate pipe (start, len reads, pipeline drain, compare),
//   for floor(len/block_size) shifts (at least one)
// - emission then moves each element through memory read and output register,
//   len items on out_valid/out_ready, the last one flagged by out_last
// - in_ready is low from the closing item until the last result enters the
//   output register; a stalled receiver holds emission in place
// - synchronous reset returns to loading with an empty store and block_size 1
module block_rotation_min_distance_core
  import brmd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: load, sweep shifts, emit
  brmd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // memories, distance pipe, best tracking, output register
  brmd_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_ready = cmd.load_en;

endmodule

/* test/brmd_result_checker.sv */
// result checker for the block rotation minimum distance core
`timescale 1ns / 1ps

module brmd_result_checker
  import brmd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_item,
  output int                   fail_count,
  output int                   pending
);

  localparam longint DIST_CAP  = (longint'(1) << DIST_BITS) - 1;
  localparam longint DIFF_SATV = longint'(1) << 19;
  localparam int     REPORT_MAX = 10;

  logic [STEP_BITS-1:0]          block_step;
  logic signed [SAMPLE_BITS-1:0] ref_mem  [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] cand_mem [MAX_LEN];
  int                            held;
  bit                            dropped;
  int                            fails;
  int                            reported;
  out_item_t                     rotation_q [$];

  // squared distance of the reference to the candidate rotated left by offset
  function automatic longint rotation_distance(input int len, input int offset);
    longint acc;
    longint d;
    longint sq;
    int     k;
    acc = 0;
    for (int j = 0; j < len; j++) begin
      k = (j + offset) % len;
      d = longint'(ref_mem[j]) - longint'(cand_mem[k]);
      if (d < 0) d = -d;
      sq = (d >= DIFF_SATV) ? DIST_CAP : d * d;
      acc = acc + sq;
      if (acc > DIST_CAP) acc = DIST_CAP;
    end
    return acc;
  endfunction

  // search all block rotations and queue the winning rotated candidate
  task automatic close_vector();
    int        len;
    int        step;
    int        tries;
    int        best_s;
    int        off;
    longint    best_d;
    longint    d;
    out_item_t item;
    len   = held;
    step  = (block_step == 0) ? 1 : int'(block_step);
    tries = len / step;
    if (tries == 0) tries = 1;
    best_s = 0;
    best_d = rotation_distance(len, 0);
    for (int s = 1; s < tries; s++) begin
      d = rotation_distance(len, (s * step) % len);
      if (d < best_d) begin
        best_d = d;
        best_s = s;
      end
    end
    off = (best_s * step) % len;
    for (int j = 0; j < len; j++) begin
      item.out_sample      = cand_mem[(j + off) % len];
      item.min_sq_distance = best_d[DIST_BITS-1:0];
      item.best_shift      = best_s[SHIFT_BITS-1:0];
      item.length_overflow = dropped;
      item.out_last        = (j == len - 1);
      rotation_q.push_back(item);
    end
    held    = 0;
    dropped = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      fails++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (rotation_q.size() == 0) begin
      fails++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("%0t: result item with none expected, out_sample %0d", $time,
                 got.out_sample);
      end
    end else begin
      want = rotation_q.pop_front();
      compare_field("out_sample", want.out_sample, got.out_sample);
      compare_field("min_sq_distance", {26'd0, want.min_sq_distance},
                    {26'd0, got.min_sq_distance});
      compare_field("best_shift", {58'd0, want.best_shift}, {58'd0, got.best_shift});
      compare_field("length_overflow", {63'd0, want.length_overflow},
                    {63'd0, got.length_overflow});
      compare_field("out_last", {63'd0, want.out_last}, {63'd0, got.out_last});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      block_step = STEP_BITS'(1);
      held       = 0;
      dropped    = 1'b0;
      rotation_q.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      if (cfg_we) block_step = cfg_data;
      if (in_valid && in_ready) begin
        if (held < MAX_LEN) begin
          ref_mem[held]  = in_item.ref_sample;
          cand_mem[held] = in_item.cand_sample;
          held++;
        end else begin
          dropped = 1'b1;
        end
        if (in_item.last_element) close_vector();
      end
    end
    fail_count <= fails;
    pending    <= rotation_q.size();
  end

endmodule

/* test/tb_block_rotation_min_distance_core.sv */
// testbench top for the block rotation minimum distance core
`timescale 1ns / 1ps

module tb_block_rotation_min_distance_core;
  import brmd_pkg::*;

  localparam int VEC_DEPTH   = 64;
  localparam int SEG_ITEMS   = 38;   // per-segment threshold, last vector overshoots; ~410 overall
  localparam int HOLD_CYCLES = 600;  // long receiver hold-off
  localparam int SETTLE      = 8;    // quiet cycles before a register write
  localparam int TAIL        = 20;   // quiet cycles before the verdict

  typedef enum {VEC_RANDOM, VEC_ROTATED, VEC_EXTREME, VEC_FLAT} vec_kind_e;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 cfg_we   = 1'b0;
  logic [STEP_BITS-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  in_item_t             in_item  = '0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  out_item_t            out_item;
  int                   fail_count;
  int                   pending;

  // idle odds in percent, block size last written, hold-off request
  int send_idle = 31;
  int recv_idle = 54;
  int cur_block = 1;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  always #10 clk = ~clk;

  block_rotation_min_distance_core #(
    .MAX_LEN(VEC_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // watches both channels, predicts the rotated vectors and compares
  brmd_result_checker #(
    .MAX_LEN(VEC_DEPTH)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver: random stalls, or a long hold-off counted here when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // offer one item; valid stays high after acceptance unless a gap follows
  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] r,
                           input logic signed [SAMPLE_BITS-1:0] c, input logic last);
    in_item_t item;
    item.ref_sample   = r;
    item.cand_sample  = c;
    item.last_element = last;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every queued result has been taken
  // pending is registered, so look only from the next edge on
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write only with the core drained and settled
  task automatic write_block_size(input int v);
    wait_results_done();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[STEP_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_block = v & 'h7f;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] extreme_sample();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // one whole vector; the rotated kind hides a block rotation of the
  // reference (plus small noise) in the candidate so nonzero shifts can win
  task automatic send_vector(input int len, input vec_kind_e kind);
    logic signed [SAMPLE_BITS-1:0] rv [0:79];
    logic signed [SAMPLE_BITS-1:0] cv [0:79];
    logic signed [SAMPLE_BITS-1:0] level;
    int step;
    int tries;
    int rot;
    step  = (cur_block == 0) ? 1 : cur_block;
    tries = len / step;
    rot   = (tries > 1) ? step * $urandom_range(tries - 1) : 0;
    level = SAMPLE_BITS'($urandom_range(65535));
    for (int j = 0; j < len; j++) begin
      case (kind)
        VEC_EXTREME: begin
          rv[j] = extreme_sample();
          cv[j] = extreme_sample();
        end
        VEC_FLAT: begin
          // constant candidate: every rotation ties, shift 0 must win
          rv[j] = SAMPLE_BITS'($urandom_range(65535));
          cv[j] = level;
        end
        default: begin
          rv[j] = SAMPLE_BITS'($urandom_range(65535));
          cv[j] = SAMPLE_BITS'($urandom_range(65535));
        end
      endcase
    end
    if (kind == VEC_ROTATED) begin
      for (int j = 0; j < len; j++) begin
        cv[(j + rot) % len] = SAMPLE_BITS'(int'(rv[j]) + int'($urandom_range(6)) - 3);
      end
    end
    for (int j = 0; j < len; j++) send_item(rv[j], cv[j], j == len - 1);
  endtask

  initial begin : stimulus
    int        n;
    int        len;
    int        pick;
    vec_kind_e kind;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single element vector at the widest difference
    send_item(16'sh8000, 16'sh7fff, 1'b1);
    // candidate is the reference rotated by two, block size 1 from reset
    send_item(16'sh7fff, 16'sh0000, 1'b0);
    send_item(16'sh8000, 16'sh0001, 1'b0);
    send_item(16'sh0000, 16'sh7fff, 1'b0);
    send_item(16'sh0001, 16'sh8000, 1'b1);
    // all rotations tie, earliest shift wins
    send_item(16'sd5, -16'sd7, 1'b0);
    send_item(16'sd5, -16'sd7, 1'b0);
    send_item(16'sd5, -16'sd7, 1'b1);
    // zero block size behaves as one, best rotation by one
    write_block_size(0);
    send_item(16'sd100, -16'sd400, 1'b0);
    send_item(-16'sd200, 16'sd100, 1'b0);
    send_item(16'sd300, -16'sd200, 1'b0);
    send_item(-16'sd400, 16'sd300, 1'b1);
    // block longer than the vector: only the unrotated candidate
    write_block_size(64);
    send_vector(5, VEC_RANDOM);
    // block of three over seven elements, rotation by one block wins
    write_block_size(3);
    send_item(16'sd1, 16'sd5, 1'b0);
    send_item(16'sd2, 16'sd6, 1'b0);
    send_item(16'sd3, 16'sd7, 1'b0);
    send_item(16'sd4, 16'sd1, 1'b0);
    send_item(16'sd5, 16'sd2, 1'b0);
    send_item(16'sd6, 16'sd3, 1'b0);
    send_item(16'sd7, 16'sd4, 1'b1);

    // random segments: two per idling mode, a new block size each
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0, 1: begin
          send_idle = 31;
          recv_idle = 54;
        end
        2, 3: begin
          send_idle = 54;
          recv_idle = 31;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (seg)
        0:       write_block_size(1);
        1:       write_block_size(127);
        2:       write_block_size(2);
        3:       write_block_size(64);
        4:       write_block_size($urandom_range(3, 8));
        default: write_block_size(0);
      endcase

      // receiver holds off while vectors keep coming, so the core backs up
      if (seg == 1) begin
        hold_req = 1'b1;
        repeat (3) send_vector(12, VEC_ROTATED);
      end

      n = 0;
      while (n < SEG_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 8)       len = $urandom_range(65, 72);  // overflows the store
        else if (pick < 20) len = $urandom_range(33, 64);
        else                len = $urandom_range(1, 16);
        pick = $urandom_range(99);
        if (pick < 45)      kind = VEC_ROTATED;
        else if (pick < 75) kind = VEC_RANDOM;
        else if (pick < 90) kind = VEC_EXTREME;
        else                kind = VEC_FLAT;
        send_vector(len, kind);
        // sender pauses once mid-segment until the core has emptied
        if (seg == 3 && n == 0) wait_results_done();
        n += len;
      end
    end

    wait_results_done();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit: 10 ms
  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
